### rtl/rgb_led_matrix_pwm_scanner_macros.svh
// Assertion helpers used by the checker file.
`ifndef RGB_LED_MATRIX_PWM_SCANNER_MACROS_SVH
`define RGB_LED_MATRIX_PWM_SCANNER_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define RGBMX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define RGBMX_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/rgbmx_pkg.sv
package rgbmx_pkg;

	// Default geometry
	localparam int ROWS_DEF   = 8;
	localparam int COLS_DEF   = 8;
	localparam int COLORS_DEF = 3;
	localparam int LEVELS_DEF = 64;

	// Field widths
	localparam int OPCODE_W  = 1;
	localparam int PROW_W    = 3;
	localparam int PCOL_W    = 3;
	localparam int PCOLOR_W  = 2;
	localparam int BRIGHT_W  = 8;
	localparam int DRIVE_W   = 24;
	localparam int ROW_EN_W  = 8;

	// Input tdata layout
	localparam int PROW_LSB   = 0;
	localparam int PCOL_LSB   = PROW_LSB + PROW_W;
	localparam int PCOLOR_LSB = PCOL_LSB + PCOL_W;
	localparam int BRIGHT_LSB = PCOLOR_LSB + PCOLOR_W;
	localparam int S_DATA_W   = 16;

	// Output tdata layout
	localparam int DRIVE_LSB  = 0;
	localparam int ROW_EN_LSB = DRIVE_LSB + DRIVE_W;
	localparam int M_DATA_W   = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

endpackage

### rtl/rgbmx_ram.sv
module rgbmx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/rgb_led_matrix_pwm_scanner.sv
// Channel  Dir  tdata (low bit up)                          tuser / tlast
// s_*      in   pixel_row, pixel_col, pixel_color, bright.  tuser: opcode
// m_*      out  column_drive, row_enable                    tlast: frame_done
//
// One request per cycle while s_tready is high; an accepted scan tick gives
// its result after the row memory read, then the compare into the output
// register. Write requests give no result.
// Reset clears the scan position and the per-entry valid bits, so the whole
// brightness store reads as zero at once; no clearing pass.
// A stalled output holds; s_tready drops only when both stages are full.
module rgb_led_matrix_pwm_scanner #(
	parameter int ROWS   = rgbmx_pkg::ROWS_DEF,
	parameter int COLS   = rgbmx_pkg::COLS_DEF,
	parameter int COLORS = rgbmx_pkg::COLORS_DEF,
	parameter int LEVELS = rgbmx_pkg::LEVELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// pixel_row[2:0], pixel_col[5:3], pixel_color[7:6], brightness[15:8]
	input  logic [rgbmx_pkg::S_DATA_W-1:0]    s_tdata,
	// opcode[0]
	input  logic [rgbmx_pkg::OPCODE_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// column_drive[23:0], row_enable[31:24]
	output logic [rgbmx_pkg::M_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast
);

	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PH_W   = $clog2(LEVELS + 1);
	localparam int NLANES = COLS * COLORS;
	localparam int NVIS   = (NLANES < rgbmx_pkg::DRIVE_W) ? NLANES : rgbmx_pkg::DRIVE_W;
	localparam int BW     = rgbmx_pkg::BRIGHT_W;
	localparam int CMP_W  = BW + 1;

	// Unpacked request fields
	logic [rgbmx_pkg::PROW_W-1:0]   pixel_row;
	logic [rgbmx_pkg::PCOL_W-1:0]   pixel_col;
	logic [rgbmx_pkg::PCOLOR_W-1:0] pixel_color;
	logic [BW-1:0]                  brightness;

	assign pixel_row   = s_tdata[rgbmx_pkg::PROW_LSB +: rgbmx_pkg::PROW_W];
	assign pixel_col   = s_tdata[rgbmx_pkg::PCOL_LSB +: rgbmx_pkg::PCOL_W];
	assign pixel_color = s_tdata[rgbmx_pkg::PCOLOR_LSB +: rgbmx_pkg::PCOLOR_W];
	assign brightness  = s_tdata[rgbmx_pkg::BRIGHT_LSB +: BW];

	logic s_accept, tick_acc, write_acc, write_ok;
	logic s1_valid_s1, out_load;

	assign out_load  = s1_valid_s1 && (!m_tvalid || m_tready);
	assign s_tready  = !s1_valid_s1 || !m_tvalid || m_tready;
	assign s_accept  = s_tvalid && s_tready;
	assign tick_acc  = s_accept && (s_tuser == rgbmx_pkg::OP_TICK);
	assign write_acc = s_accept && (s_tuser == rgbmx_pkg::OP_WRITE);
	assign write_ok  = write_acc && (32'(pixel_row) < ROWS) && (32'(pixel_col) < COLS)
		&& (32'(pixel_color) < COLORS);

	// Scan position
	logic [ROW_W-1:0] row_q;
	logic [PH_W-1:0]  phase_q;
	logic             at_end, last_row;
	logic [ROW_W-1:0] shown_row;
	logic             show_row;
	logic [rgbmx_pkg::ROW_EN_W-1:0] row_en_next;

	assign at_end   = (phase_q == PH_W'(LEVELS));
	assign last_row = (row_q == ROW_W'(ROWS - 1));

	always_comb begin
		shown_row = row_q;
		show_row  = 1'b1;
		if (at_end) begin
			if (last_row) begin
				show_row = 1'b0;
			end else begin
				shown_row = row_q + ROW_W'(1);
			end
		end
		for (int i = 0; i < rgbmx_pkg::ROW_EN_W; i++) begin
			row_en_next[i] = show_row && (32'(shown_row) == i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			phase_q <= '0;
		end else if (tick_acc) begin
			if (!at_end) begin
				phase_q <= phase_q + PH_W'(1);
			end else begin
				phase_q <= '0;
				row_q   <= last_row ? '0 : row_q + ROW_W'(1);
			end
		end
	end

	// Valid bits: an entry never written reads as zero
	logic [NVIS-1:0] valid_q [ROWS];
	logic [NVIS-1:0] lane_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				valid_q[r] <= '0;
			end
		end else if (write_ok) begin
			valid_q[ROW_W'(pixel_row)] <= valid_q[ROW_W'(pixel_row)] | lane_we;
		end
	end

	// One row-addressed memory per channel position
	logic [BW-1:0] lane_rd [NVIS];

	for (genvar l = 0; l < NVIS; l++) begin : g_lane
		assign lane_we[l] = write_ok && (32'(pixel_col) == l / COLORS)
			&& (32'(pixel_color) == l % COLORS);

		rgbmx_ram #(
			.WIDTH (BW),
			.DEPTH (ROWS)
		) u_ram (
			.clk   (clk),
			.we    (lane_we[l]),
			.waddr (ROW_W'(pixel_row)),
			.wdata (brightness),
			.re    (tick_acc),
			.raddr (row_q),
			.rdata (lane_rd[l])
		);
	end

	// Stage 1: memory data arrives here
	logic [PH_W-1:0]                phase_s1;
	logic                           on_s1;
	logic [NVIS-1:0]                valid_s1;
	logic [rgbmx_pkg::ROW_EN_W-1:0] row_en_s1;
	logic                           done_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			s1_valid_s1 <= tick_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			phase_s1  <= phase_q;
			on_s1     <= !at_end;
			valid_s1  <= valid_q[row_q];
			row_en_s1 <= row_en_next;
			done_s1   <= at_end && last_row;
		end
	end

	logic [rgbmx_pkg::DRIVE_W-1:0] drive_s1;

	always_comb begin
		drive_s1 = '0;
		for (int l = 0; l < NVIS; l++) begin
			drive_s1[l] = on_s1 && valid_s1[l] && (CMP_W'(lane_rd[l]) > CMP_W'(phase_s1));
		end
	end

	// Output register
	logic m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			m_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {row_en_s1, drive_s1};
			m_tlast <= done_s1;
		end
	end

	assign m_tvalid = m_valid_q;

endmodule

### rtl/rgbmx_checker.sv
`include "rgb_led_matrix_pwm_scanner_macros.svh"

module rgbmx_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rgbmx_pkg::M_DATA_W-1:0] m_tdata,
	input logic                           m_tlast
);

	logic [rgbmx_pkg::ROW_EN_W-1:0] row_en;
	logic [rgbmx_pkg::DRIVE_W-1:0]  drive;
	logic                           frame_end;
	logic                           stall;
	logic [rgbmx_pkg::M_DATA_W:0]   beat;

	assign row_en    = m_tdata[rgbmx_pkg::ROW_EN_LSB +: rgbmx_pkg::ROW_EN_W];
	assign drive     = m_tdata[rgbmx_pkg::DRIVE_LSB +: rgbmx_pkg::DRIVE_W];
	assign frame_end = m_tvalid && m_tlast;
	assign stall     = m_tvalid && !m_tready;
	assign beat      = {m_tlast, m_tdata};

	`RGBMX_ASSERT(a_row_onehot, m_tvalid |-> $onehot0(row_en), "row enable not one-hot")
	`RGBMX_ASSERT(a_done_no_row, frame_end |-> (row_en == '0), "row powered at frame end")
	`RGBMX_ASSERT(a_done_dark, frame_end |-> (drive == '0), "columns lit at frame end")
	`RGBMX_ASSERT(a_stall_hold, stall |=> (m_tvalid && $stable(beat)), "stalled result changed")

endmodule

bind rgb_led_matrix_pwm_scanner rgbmx_checker u_rgbmx_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
